/* rtl/shm_pkg.sv */
// Shared types, constants and helpers for the stride histogram monitor.
// No dependencies; used by every other file of the block.
`default_nettype none

package shm_pkg;

  localparam int unsigned AddrW   = 64;
  localparam int unsigned KindW   = 2;
  localparam int unsigned StrideW = 8;
  localparam int unsigned CountW  = 32;
  localparam int unsigned DistW   = 9;
  localparam int unsigned LimitW  = 16;
  localparam int unsigned Bins    = 1 << StrideW;

  localparam int unsigned StrideLimitDef = 255;

  localparam logic [CountW-1:0] PlainWeight = CountW'(1);
  localparam logic [CountW-1:0] MatchWeight = CountW'(3);

  typedef enum logic [KindW-1:0] {
    KindAccess = 2'd0,
    KindReport = 2'd1,
    KindClear  = 2'd2
  } kind_e;

  // Counter memory port request.
  typedef struct packed {
    logic               rd_en;
    logic [StrideW-1:0] rd_addr;
    logic               wr_en;
    logic [StrideW-1:0] wr_addr;
    logic [CountW-1:0]  wr_data;
    logic               clr;
  } ram_req_t;

  function automatic logic [CountW-1:0] sat_add(input logic [CountW-1:0] a,
                                                input logic [CountW-1:0] b);
    logic [CountW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CountW] ? '1 : s[CountW-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/shm_if.sv */
// Request and response channel interfaces of the stride histogram monitor.
// Depends on shm_pkg for field widths.
`default_nettype none

interface shm_req_if;
  logic                          valid;
  logic                          ready;
  logic [shm_pkg::KindW-1:0]     kind;
  logic [shm_pkg::AddrW-1:0]     address;
  modport source (output valid, kind, address, input ready);
  modport sink   (input valid, kind, address, output ready);
endinterface

interface shm_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [shm_pkg::StrideW-1:0]   top_stride;
  logic [shm_pkg::CountW-1:0]    top_count;
  logic [shm_pkg::StrideW-1:0]   next_stride;
  logic [shm_pkg::CountW-1:0]    next_count;
  logic [shm_pkg::CountW-1:0]    total_count;
  logic [shm_pkg::DistW-1:0]     distinct_strides;
  logic                          has_top;
  logic                          has_next;
  modport source (output valid, top_stride, top_count, next_stride, next_count,
                  total_count, distinct_strides, has_top, has_next, input ready);
  modport sink   (input valid, top_stride, top_count, next_stride, next_count,
                  total_count, distinct_strides, has_top, has_next, output ready);
endinterface

`default_nettype wire

/* rtl/shm_hist_ram.sv */
// Stride counter memory: 256 x 32 synchronous RAM with registered reads and
// per-entry valid bits so a clear empties the whole RAM. Depends on shm_pkg.
`default_nettype none

module shm_hist_ram (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire shm_pkg::ram_req_t          req_i,
  output logic [shm_pkg::CountW-1:0]      rd_data_o
);

  logic [shm_pkg::CountW-1:0] mem_q [shm_pkg::Bins];
  logic [shm_pkg::Bins-1:0]   vld_q;
  logic [shm_pkg::CountW-1:0] rd_q;
  logic                       rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_addr];
    end
  end

  // Clear wins over a write landing on the same edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

/* rtl/stride_histogram_monitor.sv */
// Stride histogram monitor top level.
// Depends on shm_pkg, shm_if (shm_req_if, shm_rsp_if) and shm_hist_ram.
`default_nettype none

// Accesses may follow back to back: the stride counter is read from the
// 256-entry counter RAM on acceptance and written back, saturated, in the
// following cycle, with forwarding when consecutive accesses hit the same
// stride. A clear request resets all counters at once (per-entry valid bits
// in the RAM). A report request scans all 256 counters through the RAM's
// single read port, one per cycle, and its response is registered once the
// last counter has been ranked; no request is taken during the scan. The
// response sits in an output register; accesses and clears are still taken
// while it waits, a new report is held off until it has been taken.

module stride_histogram_monitor #(
  parameter int unsigned STRIDE_LIMIT = shm_pkg::StrideLimitDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  shm_req_if.sink    req_i,
  shm_rsp_if.source  rsp_o
);

  typedef enum logic {StIdle, StScan} state_e;

  localparam logic [shm_pkg::LimitW-1:0] Limit = shm_pkg::LimitW'(STRIDE_LIMIT);

  state_e state_q;

  // Address history, kept as last address plus the two last strides.
  logic [shm_pkg::AddrW-1:0]   r0_q;
  logic [1:0]                  fill_q;
  logic [shm_pkg::StrideW-1:0] s1_q, s2_q;
  logic                        s1_ok_q, s2_ok_q;

  // Write-back stage.
  logic                        p1_vld_q;
  logic [shm_pkg::StrideW-1:0] p1_idx_q;
  logic                        p1_match_q;
  logic                        fwd_q;
  logic [shm_pkg::CountW-1:0]  last_wd_q;

  // Scan.
  logic [shm_pkg::StrideW:0]   cnt_q;
  logic                        sc_vld_q;
  logic [shm_pkg::StrideW-1:0] sc_idx_q;
  logic [shm_pkg::StrideW-1:0] top_i_q, next_i_q, top_i_d, next_i_d;
  logic [shm_pkg::CountW-1:0]  top_c_q, next_c_q, top_c_d, next_c_d;
  logic [shm_pkg::CountW-1:0]  total_q, total_d;
  logic [shm_pkg::DistW-1:0]   dist_q, dist_d;

  logic                        out_vld_q;

  shm_pkg::ram_req_t           ram_req;
  logic [shm_pkg::CountW-1:0]  ram_rd;

  logic                        req_fire, is_access, is_report, is_clear;
  logic [shm_pkg::AddrW-1:0]   addr_diff;
  logic [shm_pkg::StrideW-1:0] d8;
  logic                        d_small, count_en, match;
  logic [shm_pkg::CountW-1:0]  base, wr_data;

  assign is_access = req_i.kind == shm_pkg::KindAccess;
  assign is_report = req_i.kind == shm_pkg::KindReport;
  assign is_clear  = req_i.kind == shm_pkg::KindClear;

  assign req_i.ready = (state_q == StIdle) && !(is_report && out_vld_q);
  assign req_fire    = req_i.valid && req_i.ready;

  always_comb begin
    addr_diff = (req_i.address > r0_q) ? (req_i.address - r0_q) : (r0_q - req_i.address);
    d8        = addr_diff[shm_pkg::StrideW-1:0];
    d_small   = addr_diff[shm_pkg::AddrW-1:shm_pkg::StrideW] == '0;
    count_en  = (fill_q != 2'd0) && d_small &&
                ({{(shm_pkg::LimitW-shm_pkg::StrideW){1'b0}}, d8} <= Limit);
    match     = (fill_q == 2'd3) && s1_ok_q && s2_ok_q && (s1_q == d8) && (s2_q == d8);
  end

  always_comb begin
    base    = fwd_q ? last_wd_q : ram_rd;
    wr_data = shm_pkg::sat_add(base, p1_match_q ? shm_pkg::MatchWeight
                                                : shm_pkg::PlainWeight);
  end

  always_comb begin
    ram_req.rd_en   = (req_fire && is_access) ||
                      (state_q == StScan && !cnt_q[shm_pkg::StrideW]);
    ram_req.rd_addr = (state_q == StScan) ? cnt_q[shm_pkg::StrideW-1:0] : d8;
    ram_req.wr_en   = p1_vld_q;
    ram_req.wr_addr = p1_idx_q;
    ram_req.wr_data = wr_data;
    ram_req.clr     = req_fire && is_clear;
  end

  shm_hist_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ram_req),
    .rd_data_o (ram_rd)
  );

  // Running ranking over the scanned counters; ties keep the smaller stride.
  always_comb begin
    top_i_d  = top_i_q;
    top_c_d  = top_c_q;
    next_i_d = next_i_q;
    next_c_d = next_c_q;
    total_d  = total_q;
    dist_d   = dist_q;
    if (sc_vld_q && ram_rd != '0) begin
      dist_d  = dist_q + 1'b1;
      total_d = shm_pkg::sat_add(total_q, ram_rd);
      if (ram_rd > top_c_q) begin
        next_i_d = top_i_q;
        next_c_d = top_c_q;
        top_i_d  = sc_idx_q;
        top_c_d  = ram_rd;
      end else if (ram_rd > next_c_q) begin
        next_i_d = sc_idx_q;
        next_c_d = ram_rd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      r0_q       <= '0;
      fill_q     <= '0;
      s1_q       <= '0;
      s2_q       <= '0;
      s1_ok_q    <= 1'b0;
      s2_ok_q    <= 1'b0;
      p1_vld_q   <= 1'b0;
      fwd_q      <= 1'b0;
      cnt_q      <= '0;
      sc_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      p1_vld_q <= req_fire && is_access && count_en;
      fwd_q    <= req_fire && is_access && count_en && p1_vld_q && (p1_idx_q == d8);
      if (rsp_o.valid && rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          sc_vld_q <= 1'b0;
          if (req_fire && is_access) begin
            r0_q    <= req_i.address;
            s1_q    <= d8;
            s1_ok_q <= d_small;
            s2_q    <= s1_q;
            s2_ok_q <= s1_ok_q;
            if (fill_q != 2'd3) begin
              fill_q <= fill_q + 2'd1;
            end
          end else if (req_fire && is_clear) begin
            r0_q    <= '0;
            fill_q  <= '0;
            s1_ok_q <= 1'b0;
            s2_ok_q <= 1'b0;
          end else if (req_fire && is_report) begin
            state_q <= StScan;
            cnt_q   <= '0;
          end
        end
        StScan: begin
          sc_vld_q <= !cnt_q[shm_pkg::StrideW];
          if (!cnt_q[shm_pkg::StrideW]) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (sc_vld_q && sc_idx_q == '1) begin
            state_q   <= StIdle;
            out_vld_q <= 1'b1;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (p1_vld_q) begin
      last_wd_q <= wr_data;
    end
    if (req_fire && is_access) begin
      p1_idx_q   <= d8;
      p1_match_q <= match;
    end
    sc_idx_q <= cnt_q[shm_pkg::StrideW-1:0];
    if (req_fire && is_report) begin
      top_i_q  <= '0;
      top_c_q  <= '0;
      next_i_q <= '0;
      next_c_q <= '0;
      total_q  <= '0;
      dist_q   <= '0;
    end else begin
      top_i_q  <= top_i_d;
      top_c_q  <= top_c_d;
      next_i_q <= next_i_d;
      next_c_q <= next_c_d;
      total_q  <= total_d;
      dist_q   <= dist_d;
    end
    if (state_q == StScan && sc_vld_q && sc_idx_q == '1) begin
      rsp_o.top_stride       <= top_i_d;
      rsp_o.top_count        <= top_c_d;
      rsp_o.next_stride      <= next_i_d;
      rsp_o.next_count       <= next_c_d;
      rsp_o.total_count      <= total_d;
      rsp_o.distinct_strides <= dist_d;
      rsp_o.has_top          <= dist_d != '0;
      rsp_o.has_next         <= dist_d[shm_pkg::DistW-1:1] != '0;
    end
  end

  assign rsp_o.valid = out_vld_q;

endmodule

`default_nettype wire

/* rtl/shm_checker.sv */
// Port-level checks for the stride histogram monitor, bound to its top level.
// Depends on shm_pkg and stride_histogram_monitor.
`default_nettype none

module shm_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          rsp_valid_i,
  input wire logic                          rsp_ready_i,
  input wire logic [shm_pkg::StrideW-1:0]   top_stride_i,
  input wire logic [shm_pkg::CountW-1:0]    top_count_i,
  input wire logic [shm_pkg::CountW-1:0]    next_count_i,
  input wire logic [shm_pkg::CountW-1:0]    total_count_i,
  input wire logic [shm_pkg::DistW-1:0]     distinct_strides_i,
  input wire logic                          has_top_i,
  input wire logic                          has_next_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(top_count_i) &&
                                    $stable(top_stride_i))
    else $error("response dropped or changed while stalled");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (has_top_i == (distinct_strides_i != '0)) &&
                    (has_next_i == (distinct_strides_i > shm_pkg::DistW'(1))))
    else $error("presence flags disagree with distinct count");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !has_top_i |-> top_count_i == '0 && next_count_i == '0 &&
                                  total_count_i == '0 && top_stride_i == '0)
    else $error("empty histogram reports nonzero data");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && has_top_i |-> top_count_i >= next_count_i &&
                                 total_count_i >= top_count_i && top_count_i != '0)
    else $error("ranking or total inconsistent");

endmodule

bind stride_histogram_monitor shm_checker u_shm_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .top_stride_i       (rsp_o.top_stride),
  .top_count_i        (rsp_o.top_count),
  .next_count_i       (rsp_o.next_count),
  .total_count_i      (rsp_o.total_count),
  .distinct_strides_i (rsp_o.distinct_strides),
  .has_top_i          (rsp_o.has_top),
  .has_next_i         (rsp_o.has_next)
);

`default_nettype wire
